FILE: hw/rtl/multi_pipe_byte_fifo_macros.svh
// assertion macros for the byte pipe bank
`ifndef MULTI_PIPE_BYTE_FIFO_MACROS_SVH
`define MULTI_PIPE_BYTE_FIFO_MACROS_SVH

// same-cycle implication
`define MPBF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPBF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mpbf_pkg.sv
// shared types and codes for the byte pipe bank
package mpbf_pkg;

    localparam int CNT_W = 7;

    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_BAD_PIPE    = 3'd1,
        STAT_TOO_LONG    = 3'd2,
        STAT_WOULD_BLOCK = 3'd3,
        STAT_REFUSED     = 3'd4,
        STAT_STRAY       = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_READ
    } seq_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] pipe;
        logic [7:0] length;
        logic       first;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [7:0]       data_res;
        logic             last;
        logic [CNT_W-1:0] fill_count;
        logic [CNT_W-1:0] capacity;
    } out_item_t;

endpackage

FILE: hw/rtl/mpbf_ram.sv
// single-port byte buffer memory with registered read data
module mpbf_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/mpbf_ctrl.sv
// request sequencer with per-pipe pointers, counts and write session
module mpbf_ctrl import mpbf_pkg::*; #(
    parameter int PIPE_COUNT = 4,
    parameter int PIPE_BYTES = 64,
    parameter int AW         = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  in_item_t      s_item,
    output logic          s_ready,
    input  logic          out_free,
    output logic          res_load,
    output out_item_t     res,
    output logic          ram_we,
    output logic          ram_re,
    output logic [AW-1:0] ram_addr,
    output logic [7:0]    ram_wdata,
    input  logic [7:0]    ram_rdata
);

    localparam int PIW = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
    localparam int PTW = (PIPE_BYTES > 1) ? $clog2(PIPE_BYTES) : 1;

    seq_state_t state_reg, state_next;
    in_item_t   req_reg;

    logic [CNT_W-1:0] held_reg [PIPE_COUNT];
    logic [CNT_W-1:0] cap_reg  [PIPE_COUNT];
    logic [PTW-1:0]   wptr_reg [PIPE_COUNT];
    logic [PTW-1:0]   rptr_reg [PIPE_COUNT];
    logic [PIPE_COUNT-1:0] eng_reg;

    logic             sess_open_reg, sess_open_next;
    logic [PIW-1:0]   sess_pipe_reg, sess_pipe_next;
    logic [CNT_W-1:0] sess_left_reg, sess_left_next;
    logic [CNT_W-1:0] left_reg, left_next;

    logic             in_range, pok, upd, commit, rd_start, we, eng_n;
    logic [PIW-1:0]   sel;
    logic [CNT_W-1:0] cur_held, cur_cap, held_n, cap_n, free_cnt, sl;
    logic [PTW-1:0]   cur_wptr, cur_rptr, wptr_n, rptr_n, acc_ptr;
    status_t          st;

    function automatic logic [PTW-1:0] next_ptr(input logic [PTW-1:0] ptr,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] n;
        n = CNT_W'(ptr) + CNT_W'(1);
        if (n >= cap) begin
            n = '0;
        end
        return n[PTW-1:0];
    endfunction

    assign in_range = req_reg.pipe < 8'(PIPE_COUNT);
    assign sel      = in_range ? req_reg.pipe[PIW-1:0] : '0;
    assign pok      = in_range && eng_reg[sel];
    assign cur_held = held_reg[sel];
    assign cur_cap  = cap_reg[sel];
    assign cur_wptr = wptr_reg[sel];
    assign cur_rptr = rptr_reg[sel];
    assign free_cnt = cur_cap - cur_held;
    assign sl       = (sess_left_reg != '0) ? sess_left_reg - CNT_W'(1) : sess_left_reg;

    assign s_ready   = (state_reg == SEQ_IDLE);
    assign ram_we    = we && commit;
    assign ram_addr  = AW'(sel) * AW'(PIPE_BYTES) + AW'(acc_ptr);
    assign ram_wdata = req_reg.data;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    state_next = SEQ_EXEC;
                end
            end
            SEQ_EXEC: begin
                if (rd_start) begin
                    state_next = SEQ_READ;
                end else if (out_free) begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_READ: begin
                if (out_free && left_reg == CNT_W'(1)) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        st             = STAT_OK;
        upd            = 1'b0;
        we             = 1'b0;
        ram_re         = 1'b0;
        rd_start       = 1'b0;
        res_load       = 1'b0;
        commit         = 1'b0;
        acc_ptr        = cur_wptr;
        held_n         = cur_held;
        cap_n          = cur_cap;
        wptr_n         = cur_wptr;
        rptr_n         = cur_rptr;
        eng_n          = pok;
        sess_open_next = sess_open_reg;
        sess_pipe_next = sess_pipe_reg;
        sess_left_next = sess_left_reg;
        left_next      = left_reg;
        res            = '0;
        unique case (state_reg)
            SEQ_IDLE: begin
            end
            SEQ_EXEC: begin
                unique case (req_reg.kind)
                    KIND_INIT: begin
                        if (!in_range) begin
                            st = STAT_BAD_PIPE;
                        end else if (req_reg.length == '0 ||
                                     req_reg.length > 8'(PIPE_BYTES) || eng_reg[sel]) begin
                            st = STAT_REFUSED;
                        end else begin
                            upd    = 1'b1;
                            held_n = '0;
                            wptr_n = '0;
                            rptr_n = '0;
                            cap_n  = req_reg.length[CNT_W-1:0];
                            eng_n  = 1'b1;
                        end
                    end
                    KIND_WRITE: begin
                        if (req_reg.first) begin
                            sess_open_next = 1'b0;
                            if (!pok) begin
                                st = STAT_BAD_PIPE;
                            end else if (req_reg.length > 8'(cur_cap)) begin
                                st = STAT_TOO_LONG;
                            end else if (8'(free_cnt) < req_reg.length) begin
                                st = STAT_WOULD_BLOCK;
                            end else if (req_reg.length != '0) begin
                                if (cur_held >= cur_cap) begin
                                    st = STAT_WOULD_BLOCK;
                                end else begin
                                    we     = 1'b1;
                                    upd    = 1'b1;
                                    wptr_n = next_ptr(cur_wptr, cur_cap);
                                    held_n = cur_held + CNT_W'(1);
                                    if (req_reg.length > 8'd1) begin
                                        sess_open_next = 1'b1;
                                        sess_pipe_next = sel;
                                        sess_left_next = req_reg.length[CNT_W-1:0]
                                                         - CNT_W'(1);
                                    end
                                end
                            end
                        end else if (!sess_open_reg || req_reg.pipe != 8'(sess_pipe_reg)
                                     || !pok) begin
                            st = STAT_STRAY;
                        end else begin
                            if (cur_held >= cur_cap) begin
                                st = STAT_WOULD_BLOCK;
                            end else begin
                                we     = 1'b1;
                                upd    = 1'b1;
                                wptr_n = next_ptr(cur_wptr, cur_cap);
                                held_n = cur_held + CNT_W'(1);
                            end
                            sess_left_next = sl;
                            if (sl == '0 || cur_held >= cur_cap) begin
                                sess_open_next = 1'b0;
                            end
                        end
                    end
                    KIND_READ: begin
                        if (!pok) begin
                            st = STAT_BAD_PIPE;
                        end else if (req_reg.length > 8'(cur_cap)) begin
                            st = STAT_TOO_LONG;
                        end else if (8'(cur_held) < req_reg.length) begin
                            st = STAT_WOULD_BLOCK;
                        end else if (req_reg.length != '0) begin
                            rd_start  = 1'b1;
                            ram_re    = 1'b1;
                            upd       = 1'b1;
                            acc_ptr   = cur_rptr;
                            rptr_n    = next_ptr(cur_rptr, cur_cap);
                            held_n    = cur_held - req_reg.length[CNT_W-1:0];
                            left_next = req_reg.length[CNT_W-1:0];
                        end
                    end
                    KIND_QUERY: begin
                        if (!pok) begin
                            st = STAT_BAD_PIPE;
                        end
                    end
                    default: st = STAT_OK;
                endcase
                commit   = rd_start || out_free;
                res_load = !rd_start && out_free;
                res.status     = st;
                res.last       = 1'b1;
                res.fill_count = (in_range && eng_n) ? held_n : '0;
                res.capacity   = (in_range && eng_n) ? cap_n : '0;
            end
            SEQ_READ: begin
                commit    = out_free;
                res_load  = out_free;
                left_next = left_reg - CNT_W'(1);
                acc_ptr   = cur_rptr;
                if (left_reg != CNT_W'(1)) begin
                    ram_re = out_free;
                    upd    = 1'b1;
                    rptr_n = next_ptr(cur_rptr, cur_cap);
                end
                res.status     = STAT_OK;
                res.data_res   = ram_rdata;
                res.last       = (left_reg == CNT_W'(1));
                res.fill_count = cur_held;
                res.capacity   = cur_cap;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SEQ_IDLE;
            eng_reg       <= '0;
            sess_open_reg <= 1'b0;
            sess_pipe_reg <= '0;
            sess_left_reg <= '0;
            left_reg      <= '0;
            for (int i = 0; i < PIPE_COUNT; i++) begin
                held_reg[i] <= '0;
                cap_reg[i]  <= '0;
                wptr_reg[i] <= '0;
                rptr_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (commit) begin
                sess_open_reg <= sess_open_next;
                sess_pipe_reg <= sess_pipe_next;
                sess_left_reg <= sess_left_next;
                left_reg      <= left_next;
                if (upd) begin
                    held_reg[sel] <= held_n;
                    cap_reg[sel]  <= cap_n;
                    wptr_reg[sel] <= wptr_n;
                    rptr_reg[sel] <= rptr_n;
                    eng_reg[sel]  <= eng_n;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/multi_pipe_byte_fifo.sv
// byte pipe bank: one request at a time, one result register on the output
// each request is held in the request register before its result is registered on the output;
// a read's bytes come first through the registered read port of the buffer memory. a read of
// n bytes that is accepted gives n results, one a cycle when the output is not stalled; other
// requests, and reads that fail or ask for zero bytes, give one result
// reset (synchronous, active low) clears all pipes, pointers and the session
module multi_pipe_byte_fifo import mpbf_pkg::*; #(
    parameter int PIPE_COUNT = 4,
    parameter int PIPE_BYTES = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

`include "multi_pipe_byte_fifo_macros.svh"

    localparam int DEPTH = PIPE_COUNT * PIPE_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          m_valid_reg;
    out_item_t     m_item_reg;
    logic          out_free, res_load, ram_we, ram_re;
    out_item_t     res;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    assign out_free = !m_valid_reg || m_ready;

    mpbf_ctrl #(
        .PIPE_COUNT (PIPE_COUNT),
        .PIPE_BYTES (PIPE_BYTES),
        .AW         (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_item    (s_item),
        .s_ready   (s_ready),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    mpbf_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_item_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `MPBF_ASSERT_NOW(a_load_free, aclk, aresetn, res_load, out_free, "result overwritten")
    `MPBF_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_valid && s_ready, !s_ready, "request overlap")
    `MPBF_ASSERT_NOW(a_mid_read_ok, aclk, aresetn, m_valid && !m_item.last, m_item.status == STAT_OK, "bad mid result")
    `MPBF_ASSERT_NOW(a_ram_excl, aclk, aresetn, ram_we, !ram_re, "port clash")

endmodule
